// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 8;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int STATUS_W = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] item_data;
        logic        [PRIO_W-1:0] item_priority;
    } t_req;

    typedef struct packed {
        logic        [STATUS_W-1:0] status;
        logic signed [DATA_W-1:0]   removed_data;
        logic        [PRIO_W-1:0]   removed_priority;
    } t_rsp;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_op;

endpackage

`default_nettype wire

// ===== src/spq_stream_if.sv =====
`default_nettype none

interface spq_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire spq_pkg::t_cell_op i_op,
    input  wire spq_pkg::t_entry  i_new,
    input  wire logic             i_left_valid,
    input  wire logic             i_left_keep,
    input  wire spq_pkg::t_entry  i_left_entry,
    input  wire logic             i_right_valid,
    input  wire spq_pkg::t_entry  i_right_entry,
    output logic                  o_valid,
    output logic                  o_keep,
    output spq_pkg::t_entry       o_entry
);

    logic            r_valid;
    logic            n_valid;
    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // entry stays in place on insert when it ranks at or above the new one
    assign o_keep  = r_valid && (r_entry.prio >= i_new.prio);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_op.ins && !o_keep) begin
            if (i_left_keep) begin
                // the gap opens here: take the new word
                n_valid = 1'b1;
                n_entry = i_new;
            end else if (i_left_valid) begin
                // shift one slot toward the tail
                n_valid = 1'b1;
                n_entry = i_left_entry;
            end
        end else if (i_op.del) begin
            // advance one slot toward the head
            n_valid = i_right_valid;
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`default_nettype none

// Response: a request word accepted at one edge has its response word registered
//   at that edge, and the response word shows on the output channel after it.
// Throughput: one request per cycle while responses drain; every cell compares and
//   shifts in the same cycle, and a response held by a stalled output blocks requests.
// Reset: synchronous, active low; empties the queue and drops any pending response.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_stream_if.sink   i_req,
    spq_stream_if.source o_rsp
);

    // Cell 0 is the head. Occupied cells form a prefix of the chain, so the
    // first and last occupied flags give empty and full directly.
    logic            cell_valid [DEPTH];
    logic            cell_keep  [DEPTH];
    spq_pkg::t_entry cell_entry [DEPTH];

    spq_pkg::t_req   req;
    spq_pkg::t_entry new_entry;
    spq_pkg::t_cell_op op;

    logic accept;
    logic full;
    logic empty;

    logic          r_rsp_valid;
    logic          n_rsp_valid;
    spq_pkg::t_rsp r_rsp;
    spq_pkg::t_rsp n_rsp;

    assign req             = i_req.payload;
    assign new_entry.data  = req.item_data;
    assign new_entry.prio  = req.item_priority;

    assign full  = cell_valid[DEPTH-1];
    assign empty = !cell_valid[0];

    // Take a request whenever the response register is free or being drained.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign op.ins = accept && (req.mode == spq_pkg::MODE_INSERT) && !full;
    assign op.del = accept && (req.mode == spq_pkg::MODE_DELETE) && !empty;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic            left_valid;
            logic            left_keep;
            spq_pkg::t_entry left_entry;
            logic            right_valid;
            spq_pkg::t_entry right_entry;

            if (k == 0) begin : g_head
                // the head sees a virtual neighbor that always ranks higher
                assign left_valid = 1'b1;
                assign left_keep  = 1'b1;
                assign left_entry = new_entry;
            end else begin : g_body
                assign left_valid = cell_valid[k-1];
                assign left_keep  = cell_keep[k-1];
                assign left_entry = cell_entry[k-1];
            end

            if (k == DEPTH - 1) begin : g_tail
                // nothing behind the tail: it empties on a delete
                assign right_valid = 1'b0;
                assign right_entry = cell_entry[k];
            end else begin : g_mid
                assign right_valid = cell_valid[k+1];
                assign right_entry = cell_entry[k+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (op),
                .i_new         (new_entry),
                .i_left_valid  (left_valid),
                .i_left_keep   (left_keep),
                .i_left_entry  (left_entry),
                .i_right_valid (right_valid),
                .i_right_entry (right_entry),
                .o_valid       (cell_valid[k]),
                .o_keep        (cell_keep[k]),
                .o_entry       (cell_entry[k])
            );
        end
    endgenerate

    // Build the response word from the head before the chain moves.
    always_comb begin
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        if (accept) begin
            n_rsp_valid              = 1'b1;
            n_rsp.status             = spq_pkg::ST_DONE;
            n_rsp.removed_data       = '0;
            n_rsp.removed_priority   = '0;
            if (req.mode == spq_pkg::MODE_INSERT) begin
                if (full) begin
                    n_rsp.status = spq_pkg::ST_FULL;
                end
            end else begin
                if (empty) begin
                    n_rsp.status = spq_pkg::ST_EMPTY;
                end else begin
                    n_rsp.removed_data     = cell_entry[0].data;
                    n_rsp.removed_priority = cell_entry[0].prio;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule

`default_nettype wire
